FILE: rtl/core/sirt_pkg.sv
// Shared types, widths and constants for the signed integer to radix text block.
// Used by the controller, the datapath and the top level; depends on nothing.
package sirt_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int VALUE_FIELD_W = 64;
    localparam int RADIX_W = 5;
    localparam int S_TDATA_W = ((VALUE_FIELD_W + RADIX_W + 7) / 8) * 8;
    localparam int CHAR_W = 8;
    localparam int M_TDATA_W = CHAR_W;

    localparam int MAG_W = VALUE_WIDTH - 1;
    localparam int CHUNK_W = 8;
    localparam int CHUNKS = (MAG_W + CHUNK_W - 1) / CHUNK_W;
    localparam int DIV_W = CHUNKS * CHUNK_W;
    localparam int CIDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int DIGIT_W = 4;
    localparam int ADDR_W = $clog2(MAG_W);
    localparam int STORE_DEPTH = 2 ** ADDR_W;
    localparam int COUNT_W = ADDR_W + 1;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;

    localparam logic [CHAR_W-1:0] GLYPHS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_LOAD,
        ST_ZERO
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic sign_emit;
        logic rd_en;
        logic dig_emit;
        logic zero_emit;
    } cmd_t;

    typedef struct packed {
        logic mag_zero;
        logic div_done;
        logic out_free;
        logic is_neg;
        logic last_digit;
    } sts_t;

endpackage

FILE: rtl/core/sirt_ctrl.sv
// Controller state machine for the radix text block: sequences load, digit division
// and character output. Depends on sirt_pkg for the state, command and status types.
module sirt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  sirt_pkg::sts_t sts,
    output sirt_pkg::cmd_t cmd
);
    import sirt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = sts.mag_zero ? ST_ZERO : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (sts.div_done) begin
                    state_next = sts.is_neg ? ST_SIGN : ST_READ;
                end
            end
            ST_SIGN: begin
                if (sts.out_free) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    state_next = sts.last_digit ? ST_IDLE : ST_READ;
                end
            end
            ST_ZERO: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CHECK: begin
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            ST_SIGN: begin
                cmd.sign_emit = sts.out_free;
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
            end
            ST_LOAD: begin
                cmd.dig_emit = sts.out_free;
            end
            ST_ZERO: begin
                cmd.zero_emit = sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/core/sirt_dp.sv
// Datapath for the radix text block: magnitude load, chunked division by the radix,
// digit memory and output register. Depends on sirt_pkg for widths, tables and types.
module sirt_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [sirt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  sirt_pkg::cmd_t                   cmd,
    output sirt_pkg::sts_t                   sts,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sirt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);
    import sirt_pkg::*;

    localparam logic [VALUE_WIDTH-1:0] TOP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [DIV_W-1:0]   mag_reg, mag_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [CIDX_W-1:0]  cidx_reg, cidx_next;
    logic [CIDX_W-1:0]  top_reg, top_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               neg_reg, neg_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [DIGIT_W-1:0] rd_data_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]  m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;

    logic [DIGIT_W-1:0] digit_store [STORE_DEPTH];

    logic [VALUE_WIDTH-1:0] in_value;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_abs;
    logic [MAG_W-1:0]       in_mag;
    logic [RADIX_W-1:0]     in_radix;
    logic [RADIX_W-1:0]     in_radix_sat;

    logic [CHUNK_W-1:0] chunk;
    logic [CHUNK_W-1:0] qchunk;
    logic [DIGIT_W-1:0] step_rem;
    logic [DIV_W-1:0]   step_mag;
    logic               step_zero;
    logic               digit_end;
    logic               out_free;

    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_neg = in_value[VALUE_WIDTH-1];
    assign in_abs = in_neg ? (~in_value + 1'b1) : in_value;
    assign in_mag = (in_abs == TOP) ? {MAG_W{1'b1}} : in_abs[MAG_W-1:0];
    assign in_radix = s_tdata[VALUE_FIELD_W +: RADIX_W];

    always_comb begin
        priority if (in_radix < RADIX_MIN) begin
            in_radix_sat = RADIX_MIN;
        end else if (in_radix > RADIX_MAX) begin
            in_radix_sat = RADIX_MAX;
        end else begin
            in_radix_sat = in_radix;
        end
    end

    assign chunk = mag_reg[CHUNK_W * cidx_reg +: CHUNK_W];

    always_comb begin
        logic [DIGIT_W:0]   t;
        logic [DIGIT_W-1:0] r;
        r = rem_reg;
        qchunk = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            t = {r, chunk[i]};
            if (t >= radix_reg) begin
                qchunk[i] = 1'b1;
                r = DIGIT_W'(t - radix_reg);
            end else begin
                r = t[DIGIT_W-1:0];
            end
        end
        step_rem = r;
    end

    always_comb begin
        step_mag = mag_reg;
        step_mag[CHUNK_W * cidx_reg +: CHUNK_W] = qchunk;
    end

    assign step_zero = (step_mag == '0);
    assign digit_end = cmd.div_step && (cidx_reg == '0);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        mag_next = mag_reg;
        rem_next = rem_reg;
        cidx_next = cidx_reg;
        top_next = top_reg;
        count_next = count_reg;
        neg_next = neg_reg;
        radix_next = radix_reg;
        if (cmd.load) begin
            mag_next = DIV_W'(in_mag);
            rem_next = '0;
            cidx_next = CIDX_W'(CHUNKS - 1);
            top_next = CIDX_W'(CHUNKS - 1);
            count_next = '0;
            neg_next = in_neg && (in_mag != '0);
            radix_next = in_radix_sat;
        end else if (cmd.div_step) begin
            mag_next = step_mag;
            if (digit_end) begin
                rem_next = '0;
                count_next = count_reg + 1'b1;
                if ((step_mag[CHUNK_W * top_reg +: CHUNK_W] == '0) && (top_reg != '0)) begin
                    top_next = top_reg - 1'b1;
                    cidx_next = top_reg - 1'b1;
                end else begin
                    cidx_next = top_reg;
                end
            end else begin
                rem_next = step_rem;
                cidx_next = cidx_reg - 1'b1;
            end
        end else if (cmd.dig_emit) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (digit_end) begin
            digit_store[count_reg[ADDR_W-1:0]] <= step_rem;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= digit_store[ADDR_W'(count_reg - 1'b1)];
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;
        m_tlast_next = m_tlast_reg;
        priority if (cmd.sign_emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next = CH_MINUS;
            m_tlast_next = 1'b0;
        end else if (cmd.dig_emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next = GLYPHS[rd_data_reg];
            m_tlast_next = (count_reg == COUNT_W'(1));
        end else if (cmd.zero_emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next = CH_ZERO;
            m_tlast_next = 1'b1;
        end else begin
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg <= '0;
            count_reg <= '0;
            neg_reg <= 1'b0;
            radix_reg <= RADIX_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            mag_reg <= mag_next;
            count_reg <= count_next;
            neg_reg <= neg_next;
            radix_reg <= radix_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rem_reg <= rem_next;
        cidx_reg <= cidx_next;
        top_reg <= top_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign sts.mag_zero = (mag_reg == '0);
    assign sts.div_done = digit_end && step_zero;
    assign sts.out_free = out_free;
    assign sts.is_neg = neg_reg;
    assign sts.last_digit = (count_reg == COUNT_W'(1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;

endmodule

FILE: rtl/core/signed_int_to_radix_text.sv
// Each input word carries a signed 64-bit value and a radix (saturated into 2..16). The block
// answers with the value's text, one ASCII character per output word, most significant first:
// '-' for a negative value, then lower-case digits; zero gives a single '0', tlast marks the
// final character, and the most negative value is printed as -(2^63-1). Each word is loaded
// and checked; then, for each digit, the divider steps through the active 8-bit chunks of the
// magnitude (it consumes eight dividend bits per cycle and drops at most one leading zero chunk
// per digit as the quotient shrinks). The sign, if any, then goes to the output register, and
// each digit is read from the digit memory and put into the output register; output stalls
// while m_tready is held low. The next input word is taken once the last character of the
// previous one sits in the output register.
// Top level: instantiates sirt_ctrl and sirt_dp; depends on sirt_pkg.
module signed_int_to_radix_text (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: value (64 bits, signed), radix (5 bits), zero padding.
    input  logic [sirt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: char_code (8 bits).
    output logic [sirt_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import sirt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sirt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sirt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: tb/signed_int_to_radix_text_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for signed_int_to_radix_text: drives value/radix words and
// checks every output character against a local prediction of the radix text.
// Depends on sirt_pkg and the signed_int_to_radix_text RTL.
module signed_int_to_radix_text_tb;
    import sirt_pkg::*;

    localparam int RANDOM_ITEMS = 350;
    localparam int TAIL_ITEMS = 40;
    localparam int DRAIN_CYCLES = 350;
    localparam int WATCHDOG_LIMIT = 6000;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } text_char_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    logic [S_TDATA_W-1:0] value_words [$];
    text_char_t           text_expected [$];
    text_char_t           head_char;
    int                   words_total = 0;
    int                   words_sent = 0;
    int                   fail_count = 0;
    int                   src_gap = 0;
    int                   snk_gap = 0;
    int                   idle_cycles = 0;
    logic                 quiet_tail;

    assign quiet_tail = (words_sent >= words_total - TAIL_ITEMS);

    signed_int_to_radix_text dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic logic [S_TDATA_W-1:0] make_word(input logic [63:0] value,
                                                       input logic [RADIX_W-1:0] radix);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[VALUE_FIELD_W-1:0] = value;
        word[VALUE_FIELD_W +: RADIX_W] = radix;
        return word;
    endfunction

    function automatic void predict_text(input logic [S_TDATA_W-1:0] word);
        string              glyphs = "0123456789abcdef";
        logic [63:0]        top;
        logic [63:0]        mask;
        logic [63:0]        mag;
        logic [RADIX_W-1:0] base;
        logic [3:0]         digits [64];
        logic               neg;
        int                 count;
        top = 64'd1 << (VALUE_WIDTH - 1);
        mask = (top << 1) - 64'd1;
        mag = word[63:0] & mask;
        base = word[VALUE_FIELD_W +: RADIX_W];
        if (base < RADIX_MIN) begin
            base = RADIX_MIN;
        end
        if (base > RADIX_MAX) begin
            base = RADIX_MAX;
        end
        neg = ((mag & top) != 64'd0);
        if (neg) begin
            mag = (~mag + 64'd1) & mask;
            if (mag == top) begin
                mag = top - 64'd1;
            end
        end
        if (mag == 64'd0) begin
            text_expected.push_back(text_char_t'{CH_ZERO, 1'b1});
            return;
        end
        count = 0;
        while (mag != 64'd0) begin
            digits[count] = 4'(mag % 64'(base));
            mag = mag / 64'(base);
            count++;
        end
        if (neg) begin
            text_expected.push_back(text_char_t'{CH_MINUS, 1'b0});
        end
        for (int i = count - 1; i >= 0; i--) begin
            text_expected.push_back(text_char_t'{CHAR_W'(glyphs[digits[i]]), i == 0});
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (value_words.size() > 0) begin
                s_tdata <= value_words.pop_front();
                s_tvalid <= 1'b1;
                words_sent <= words_sent + 1;
                if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                    src_gap <= $urandom_range(1, 15);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            m_tready <= 1'b0;
            snk_gap <= snk_gap - 1;
        end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
            m_tready <= 1'b0;
            snk_gap <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_text(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (text_expected.size() == 0) begin
                    $error("unexpected word: char_code %h last %b", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    head_char = text_expected.pop_front();
                    if (m_tdata !== head_char.char_code) begin
                        $error("char_code mismatch: expected %h, actual %h",
                               head_char.char_code, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== head_char.last) begin
                        $error("last mismatch: expected %b, actual %b", head_char.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("signed_int_to_radix_text test failed");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0]        top;
        logic [63:0]        value;
        logic [RADIX_W-1:0] radix;
        top = 64'd1 << (VALUE_WIDTH - 1);

        value_words.push_back(make_word(64'd0, 5'd10));
        value_words.push_back(make_word(64'd0, 5'd2));
        value_words.push_back(make_word(64'd1, 5'd2));
        value_words.push_back(make_word(-64'sd1, 5'd16));
        value_words.push_back(make_word(top - 64'd1, 5'd2));
        value_words.push_back(make_word(top - 64'd1, 5'd10));
        value_words.push_back(make_word(top - 64'd1, 5'd16));
        value_words.push_back(make_word(top, 5'd2));
        value_words.push_back(make_word(top, 5'd10));
        value_words.push_back(make_word(top + 64'd1, 5'd16));
        value_words.push_back(make_word(64'd5, 5'd0));
        value_words.push_back(make_word(-64'sd6, 5'd1));
        value_words.push_back(make_word(64'd255, 5'd17));
        value_words.push_back(make_word(-64'sd255, 5'd31));
        value_words.push_back(make_word(64'd0, 5'd31));
        value_words.push_back(make_word(64'd15, 5'd16));
        value_words.push_back(make_word(64'd35, 5'd3));
        value_words.push_back(make_word(-64'sd1234567890, 5'd7));
        value_words.push_back(make_word(64'hfedcba9876543210, 5'd13));
        value_words.push_back(make_word(64'd9, 5'd9));

        repeat (RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    value = {$urandom, $urandom};
                end
                4, 5, 6: begin
                    value = 64'($urandom_range(0, 1000));
                    if ($urandom_range(0, 1) == 1) begin
                        value = -value;
                    end
                end
                7, 8: begin
                    value = {$urandom, $urandom} >> $urandom_range(1, 63);
                    if ($urandom_range(0, 1) == 1) begin
                        value = -value;
                    end
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: value = 64'd0;
                        1: value = top;
                        2: value = top - 64'd1;
                        3: value = -64'sd1;
                        default: value = 64'd1;
                    endcase
                end
            endcase
            if ($urandom_range(0, 6) == 0) begin
                radix = RADIX_W'($urandom_range(0, 31));
            end else begin
                radix = RADIX_W'($urandom_range(2, 16));
            end
            value_words.push_back(make_word(value, radix));
        end
        words_total = value_words.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (value_words.size() != 0 || s_tvalid) @(posedge aclk);
        while (text_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (text_expected.size() != 0) begin
            $error("%0d expected characters never arrived", text_expected.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("signed_int_to_radix_text test passed");
        end else begin
            $display("signed_int_to_radix_text test failed");
        end
        $finish;
    end

endmodule
